### hw/rtl/nps_pkg.sv
// Shared types and constants for the nearest point search block.
// Depends on nothing; used by nearest_point_search.
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  // Store geometry and number formats
  localparam int unsigned REF_DEPTH = 1024;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned IDX_W     = $clog2(REF_DEPTH);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned DIST_W    = 50;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned SUM_W     = SQ_W + 1;
  localparam int unsigned WIDE_W    = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  // Field widths fixed by the item formats
  localparam int unsigned REF_INDEX_W = 10;
  localparam int unsigned REF_COUNT_W = 11;

  // Register reset values
  localparam logic [REF_COUNT_W-1:0] REF_COUNT_RST = REF_COUNT_W'(1024);
  localparam logic [DIST_W-1:0]      START_DIST_RST = DIST_W'(64'd10000 << 16);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DIST = 1'b1;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [REF_INDEX_W-1:0]    ref_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } cmd_t;

  typedef struct packed {
    logic [REF_INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]      nearest_distance;
    logic                   found;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/nearest_point_search.sv
// Top level of the nearest point search block: point store, distance pipeline
// and search sequencer. Depends on nps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Brute-force 2-D nearest neighbour on squared Euclidean distance.
//
// Command channel: an item (cmd_i) is taken at a rising edge with start_i high
// and busy_o low. A load item (action 0) writes one point into the store in
// that edge and leaves busy_o low, so loads may follow each other every cycle.
// A query item (action 1) raises busy_o and walks slots 0 .. limit-1, where
// limit is ref_count saturated to the store depth, one slot per cycle through
// a four-stage pipeline (store read, difference, square, compare). The result
// item appears on result_o with done_o high for exactly one cycle; busy_o
// falls in that same cycle, so the next item may be started while the result
// shows. A new query is taken only once the last one is through, as the
// single store read port fetches one slot per cycle.
//
// Configuration: cfg_we_i writes register cfg_index_i (0 ref_count,
// 1 start_distance) with cfg_data_i; write only while busy_o is low.
// Reset clears the sequencer and restores ref_count to 1024 and
// start_distance to 10000.0; the store is not cleared and a slot must be
// loaded before a query reads it. The receiver cannot stall: each result is
// taken in the cycle it is shown.

module nearest_point_search (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire nps_pkg::cmd_t                        cmd_i,
  output logic                                      busy_o,
  output logic                                      done_o,
  output nps_pkg::result_t                          result_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [nps_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [nps_pkg::DIST_W-1:0]           cfg_data_i
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  localparam int unsigned CW = nps_pkg::COORD_W;

  // Configuration registers
  logic [nps_pkg::REF_COUNT_W-1:0] ref_count_q;
  logic [nps_pkg::DIST_W-1:0]      start_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q  <= nps_pkg::REF_COUNT_RST;
      start_dist_q <= nps_pkg::START_DIST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nps_pkg::CFG_REF_COUNT:  ref_count_q  <= cfg_data_i[nps_pkg::REF_COUNT_W-1:0];
        nps_pkg::CFG_START_DIST: start_dist_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake decode
  state_e state_q;
  logic   accept;
  logic   load_go;
  logic   query_go;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign load_go  = accept && (cmd_i.action == nps_pkg::ACT_LOAD);
  assign query_go = accept && (cmd_i.action == nps_pkg::ACT_QUERY);

  // Saturate the slot count to the store depth
  logic [nps_pkg::CNT_W-1:0] limit_d;
  always_comb begin
    if (32'(ref_count_q) > nps_pkg::REF_DEPTH) begin
      limit_d = nps_pkg::CNT_W'(nps_pkg::REF_DEPTH);
    end else begin
      limit_d = nps_pkg::CNT_W'(ref_count_q);
    end
  end

  // Point store: x in the upper half of each word, y in the lower half
  logic [2*CW-1:0]           store_mem [nps_pkg::REF_DEPTH];
  logic [2*CW-1:0]           rd_data_q;
  logic [nps_pkg::IDX_W-1:0] wr_addr;
  logic                      wr_en;
  logic [nps_pkg::CNT_W-1:0] cnt_q;
  logic [nps_pkg::IDX_W-1:0] rd_addr;

  assign wr_addr = nps_pkg::IDX_W'(cmd_i.ref_index);
  assign wr_en   = load_go && (32'(cmd_i.ref_index) < nps_pkg::REF_DEPTH);
  assign rd_addr = cnt_q[nps_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= {cmd_i.point_x, cmd_i.point_y};
    end
    rd_data_q <= store_mem[rd_addr];
  end

  // Issue control: one slot per cycle while the count is below the limit
  logic [nps_pkg::CNT_W-1:0] limit_q;
  logic                      issue;
  assign issue = (state_q == ST_SEARCH) && (cnt_q < limit_q);

  // Query point, held for the whole walk
  logic signed [CW-1:0] qx_q;
  logic signed [CW-1:0] qy_q;

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      qx_q <= cmd_i.point_x;
      qy_q <= cmd_i.point_y;
    end
  end

  // Stage 1: store read in flight
  logic                      s1_v_q;
  logic [nps_pkg::IDX_W-1:0] s1_idx_q;

  // Stage 2: absolute differences
  logic signed [CW:0]        diff_x;
  logic signed [CW:0]        diff_y;
  logic [CW-1:0]             abs_x;
  logic [CW-1:0]             abs_y;
  logic                      s2_v_q;
  logic [nps_pkg::IDX_W-1:0] s2_idx_q;
  logic [CW-1:0]             dx_q;
  logic [CW-1:0]             dy_q;

  assign diff_x = $signed({qx_q[CW-1], qx_q}) -
                  $signed({rd_data_q[2*CW-1], rd_data_q[2*CW-1:CW]});
  assign diff_y = $signed({qy_q[CW-1], qy_q}) -
                  $signed({rd_data_q[CW-1], rd_data_q[CW-1:0]});
  assign abs_x  = diff_x[CW] ? CW'(-diff_x) : CW'(diff_x);
  assign abs_y  = diff_y[CW] ? CW'(-diff_y) : CW'(diff_y);

  // Stage 3: squares
  logic                      s3_v_q;
  logic [nps_pkg::IDX_W-1:0] s3_idx_q;
  logic [nps_pkg::SQ_W-1:0]  sq_x_q;
  logic [nps_pkg::SQ_W-1:0]  sq_y_q;

  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_addr;
    dx_q     <= abs_x;
    dy_q     <= abs_y;
    s2_idx_q <= s1_idx_q;
    sq_x_q   <= nps_pkg::SQ_W'(dx_q) * nps_pkg::SQ_W'(dx_q);
    sq_y_q   <= nps_pkg::SQ_W'(dy_q) * nps_pkg::SQ_W'(dy_q);
    s3_idx_q <= s2_idx_q;
  end

  // Stage 4: sum, saturate and compare against the running minimum
  logic [nps_pkg::WIDE_W-1:0] sum_wide;
  logic                       sum_sat;
  logic [nps_pkg::DIST_W-1:0] cur_dist;
  logic [nps_pkg::DIST_W-1:0] best_dist_q;
  logic [nps_pkg::IDX_W-1:0]  best_idx_q;
  logic                       hit_q;
  logic                       better;

  assign sum_wide = nps_pkg::WIDE_W'(sq_x_q) + nps_pkg::WIDE_W'(sq_y_q);
  assign sum_sat  = |(sum_wide >> nps_pkg::DIST_W);
  assign cur_dist = sum_sat ? {nps_pkg::DIST_W{1'b1}} : sum_wide[nps_pkg::DIST_W-1:0];
  assign better   = s3_v_q && (cur_dist < best_dist_q);

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      best_dist_q <= start_dist_q;
      best_idx_q  <= '0;
    end else if (better) begin
      best_dist_q <= cur_dist;
      best_idx_q  <= s3_idx_q;
    end
  end

  // Walk finished once every slot is issued and the pipeline is empty
  logic finish;
  assign finish = (state_q == ST_SEARCH) && (cnt_q == limit_q) &&
                  !s1_v_q && !s2_v_q && !s3_v_q;

  // Sequencer, pipeline valids and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      limit_q  <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      hit_q    <= 1'b0;
      done_o   <= 1'b0;
      result_o <= '0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      done_o <= 1'b0;
      if (better) begin
        hit_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (query_go) begin
            state_q <= ST_SEARCH;
            cnt_q   <= '0;
            limit_q <= limit_d;
            hit_q   <= 1'b0;
          end
        end
        ST_SEARCH: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (finish) begin
            // Hand over the result and drop back to idle
            state_q                   <= ST_IDLE;
            done_o                    <= 1'b1;
            result_o.nearest_index    <= nps_pkg::REF_INDEX_W'(best_idx_q);
            result_o.nearest_distance <= best_dist_q;
            result_o.found            <= hit_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A found result lies strictly below the start limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.found) |-> (result_o.nearest_distance < start_dist_q))
    else $error("found result not below start distance");

  // A miss reports slot zero and the start limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |->
      (result_o.nearest_index == '0 && result_o.nearest_distance == start_dist_q))
    else $error("miss result malformed");

  // Busy falls exactly when a result is handed over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy fell without a result");

  // A result lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // Pipeline only carries slots during a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q || s2_v_q || s3_v_q) |-> (state_q == ST_SEARCH))
    else $error("pipeline active outside a search");
`endif

endmodule

`default_nettype wire

### tb/nps_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the nearest point search block: mirrors the point store and
// the two registers, predicts every query item and compares each result.
// Depends on nps_pkg.

module nps_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  nps_pkg::cmd_t                 cmd_i,
  input  logic                          busy_i,
  input  logic                          done_i,
  input  nps_pkg::result_t              result_i,
  input  logic                          cfg_we_i,
  input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nps_pkg::DIST_W-1:0]    cfg_data_i,
  output int                            error_count_o,
  output int                            outstanding_o
);
  import nps_pkg::*;

  localparam logic [63:0] DIST_SAT = (64'd1 << DIST_W) - 64'd1;

  logic signed [COORD_W-1:0] x_mirror [REF_DEPTH];
  logic signed [COORD_W-1:0] y_mirror [REF_DEPTH];
  logic [REF_COUNT_W-1:0]    count_copy = REF_COUNT_RST;
  logic [DIST_W-1:0]         start_copy = START_DIST_RST;
  result_t                   nearest_due [$];
  int                        errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Walk the mirrored store in slot order; keep the first strict minimum.
  function automatic result_t nearest_of(input logic signed [COORD_W-1:0] qx,
                                         input logic signed [COORD_W-1:0] qy);
    result_t     r;
    int unsigned span;
    longint      dx;
    longint      dy;
    logic [63:0] dsq;
    logic [63:0] best;
    span = (count_copy > REF_DEPTH) ? REF_DEPTH : count_copy;
    best = 64'(start_copy);
    r.nearest_index = '0;
    r.found = 1'b0;
    for (int unsigned i = 0; i < span; i++) begin
      dx = longint'(qx) - longint'(x_mirror[i]);
      dy = longint'(qy) - longint'(y_mirror[i]);
      dsq = 64'(dx * dx + dy * dy);
      if (dsq > DIST_SAT) dsq = DIST_SAT;
      if (dsq < best) begin
        best = dsq;
        r.nearest_index = REF_INDEX_W'(i);
        r.found = 1'b1;
      end
    end
    r.nearest_distance = best[DIST_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      count_copy = REF_COUNT_RST;
      start_copy = START_DIST_RST;
      nearest_due.delete();
    end else begin
      if (done_i) begin
        if (nearest_due.size() == 0) begin
          report_mismatch("result with no query outstanding");
        end else begin
          want = nearest_due.pop_front();
          if (result_i.nearest_index !== want.nearest_index)
            report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                      result_i.nearest_index, want.nearest_index));
          if (result_i.nearest_distance !== want.nearest_distance)
            report_mismatch($sformatf("nearest_distance %0d, expected %0d",
                                      result_i.nearest_distance, want.nearest_distance));
          if (result_i.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b",
                                      result_i.found, want.found));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_REF_COUNT:  count_copy = cfg_data_i[REF_COUNT_W-1:0];
          CFG_START_DIST: start_copy = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (cmd_i.action == ACT_LOAD) begin
          if (cmd_i.ref_index < REF_DEPTH) begin
            x_mirror[cmd_i.ref_index] = cmd_i.point_x;
            y_mirror[cmd_i.ref_index] = cmd_i.point_y;
          end
        end else begin
          nearest_due = {nearest_due, nearest_of(cmd_i.point_x, cmd_i.point_y)};
        end
      end
    end
    error_count_o <= errors;
    outstanding_o <= nearest_due.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the nearest point search testbench: clock, reset, load and query
// stimulus, register settings and the verdict.
// Depends on nps_pkg, nearest_point_search and nps_checker.

module testbench;
  import nps_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 580;
  localparam longint      CYCLE_LIMIT   = 8000000;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [DIST_W-1:0]         DIST_ALL_ONES = '1;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  cmd_t                 cmd_i;
  logic                 busy_o;
  logic                 done_o;
  result_t              result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIST_W-1:0]    cfg_data_i;
  int                   error_count;
  int                   outstanding;

  nearest_point_search uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  nps_checker nearest_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .cmd_i         (cmd_i),
    .busy_i        (busy_o),
    .done_i        (done_o),
    .result_i      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung search or a lost result ends the run here.
  longint cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus-side bookkeeping. The store is undefined until written, so keep
  // track of which slots hold a point: ref_count never reaches past the run of
  // written slots that starts at slot 0 ("filled").
  logic                      written  [REF_DEPTH];
  logic signed [COORD_W-1:0] shadow_x [REF_DEPTH];
  logic signed [COORD_W-1:0] shadow_y [REF_DEPTH];
  int unsigned               filled     = 0;
  int unsigned               live_count = 0;  // slots searched in this phase
  int unsigned               coord_bits = 24; // coordinate spread of this phase
  int unsigned               calm_run   = 0;  // items left in a gap-free stretch
  int unsigned               sent       = 0;
  int unsigned               phase_len;
  int unsigned               slot;
  int unsigned               spread;

  // Draw the idle gap before each item; now and then a stretch with no idling.
  function automatic int unsigned draw_gap();
    if (calm_run != 0) begin
      calm_run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Signed coordinate spread uniformly over +/- 2^(bits-1).
  function automatic logic signed [COORD_W-1:0] rand_coord(input int unsigned bits);
    int unsigned span;
    span = 1 << bits;
    return COORD_W'($urandom_range(0, span - 1) - span / 2);
  endfunction

  function automatic logic [DIST_W-1:0] pick_start(input int unsigned bits);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return START_DIST_RST;
      1:       return DIST_ALL_ONES;
      2:       return '0;
      3, 4, 5: return DIST_W'(wide & ((64'd1 << (2 * bits + 1)) - 64'd1));
      default: return DIST_W'(wide);
    endcase
  endfunction

  // Mostly short searches; now and then none, or the written run up to 300 slots.
  function automatic int unsigned pick_count();
    int unsigned cap;
    cap = (filled < 48) ? filled : 48;
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return (filled < 300) ? filled : 300;
      default: return $urandom_range(1, cap);
    endcase
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input cmd_t item);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (item.action == ACT_LOAD) begin
      written[item.ref_index]  = 1'b1;
      shadow_x[item.ref_index] = item.point_x;
      shadow_y[item.ref_index] = item.point_y;
      while (filled < REF_DEPTH && written[filled]) filled++;
    end
  endtask

  task automatic load_point(input int unsigned idx,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    cmd_t item;
    item.action    = ACT_LOAD;
    item.ref_index = REF_INDEX_W'(idx);
    item.point_x   = x;
    item.point_y   = y;
    send_item(item);
  endtask

  // The slot field of a query is ignored; fill it with noise.
  task automatic query_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
    cmd_t item;
    item.action    = ACT_QUERY;
    item.ref_index = REF_INDEX_W'($urandom_range(0, REF_DEPTH - 1));
    item.point_x   = x;
    item.point_y   = y;
    send_item(item);
  endtask

  // Drop start, wait for every expected result and for the block to go
  // idle, then wait on so that a load in flight has landed.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; call only while idle.
  task automatic set_search(input int unsigned count, input logic [DIST_W-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_REF_COUNT;
    cfg_data_i  <= DIST_W'(count);
    @(posedge clk_i);
    cfg_index_i <= CFG_START_DIST;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    live_count = (count > REF_DEPTH) ? REF_DEPTH : count;
  endtask

  // Random query: mostly close to a searched point so that the running
  // minimum moves, otherwise within the phase spread or the full range.
  task automatic random_query();
    if (live_count != 0 && $urandom_range(0, 2) != 0) begin
      slot   = $urandom_range(0, live_count - 1);
      spread = $urandom_range(1, coord_bits);
      query_point(shadow_x[slot] + rand_coord(spread),
                  shadow_y[slot] + rand_coord(spread));
    end else if ($urandom_range(0, 7) == 0) begin
      query_point(rand_coord(COORD_W), rand_coord(COORD_W));
    end else begin
      query_point(rand_coord(coord_bits), rand_coord(coord_bits));
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < REF_DEPTH; i++) written[i] = 1'b0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_REF_COUNT;
    cfg_data_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Narrow the search first: after reset ref_count would
    // reach unwritten slots.
    set_search(5, START_DIST_RST);
    load_point(0, 0, 0);
    load_point(1, COORD_MAX, COORD_MAX);
    load_point(2, COORD_MIN, COORD_MIN);
    load_point(3, 2560, -1280);                 // (10.0, -5.0)
    load_point(4, 2560, -1280);                 // same point: ties keep slot 3
    load_point(REF_DEPTH - 1, -1, 24'h555555);  // top slot, alternating bits
    load_point(512, 24'h2AAAAA, 1);
    query_point(0, 0);
    query_point(2560, -1280);
    query_point(2561, -1280);
    query_point(COORD_MAX, COORD_MAX);
    query_point(COORD_MIN, COORD_MIN);
    query_point(COORD_MAX, COORD_MIN);          // nothing below 10000.0
    settle();
    set_search(0, START_DIST_RST);              // zero count searches nothing
    query_point(0, 0);
    settle();
    set_search(5, '0);                          // nothing is strictly below zero
    query_point(0, 0);
    settle();
    set_search(5, DIST_ALL_ONES);               // widest limit, far corners
    query_point(COORD_MAX, COORD_MIN);
    query_point(COORD_MIN, COORD_MAX);
    settle();
    set_search(1, DIST_W'(65536));              // limit equal to 1.0 squared
    query_point(256, 0);
    query_point(255, 0);
    settle();

    // Random part: phases of loads and queries, each under its own count,
    // limit and coordinate spread. Loads mostly extend the written run.
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       coord_bits = $urandom_range(4, 10);
        1:       coord_bits = $urandom_range(11, 17);
        2:       coord_bits = $urandom_range(18, 23);
        default: coord_bits = COORD_W;
      endcase
      set_search(pick_count(), pick_start(coord_bits));
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 6) begin
          if (filled < REF_DEPTH && $urandom_range(0, 9) < 7) slot = filled;
          else slot = $urandom_range(0, REF_DEPTH - 1);
          if ($urandom_range(0, 7) == 0) begin
            // copy a written point so that queries meet exact ties
            spread = $urandom_range(0, filled - 1);
            load_point(slot, shadow_x[spread], shadow_y[spread]);
          end else if ($urandom_range(0, 7) == 0) begin
            load_point(slot, rand_coord(COORD_W), rand_coord(COORD_W));
          end else begin
            load_point(slot, rand_coord(coord_bits), rand_coord(coord_bits));
          end
        end else begin
          random_query();
        end
        sent++;
      end
      settle();
    end

    // Hold on for one full search more in case a stray result turns up.
    repeat (REF_DEPTH + 16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/nps_pkg.sv
hw/rtl/nearest_point_search.sv
tb/nps_checker.sv
tb/testbench.sv
